// File: src/irv_pkg.sv
// ----------------------------------------------------------------------------
// irv_pkg
// Shared types, codes and the byte-wide CRC-32 update for the image resource
// validator.
// ----------------------------------------------------------------------------
package irv_pkg;

  // stream item codes carried in in_tuser
  localparam logic [1:0] OP_DESC = 2'd0;
  localparam logic [1:0] OP_BYTE = 2'd1;
  localparam logic [1:0] OP_END  = 2'd2;

  // result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_VERSION   = 3'd1;
  localparam logic [2:0] ST_GEOMETRY  = 3'd2;
  localparam logic [2:0] ST_SIZE      = 3'd3;
  localparam logic [2:0] ST_NO_PUBLISH = 3'd4;
  localparam logic [2:0] ST_INTEGRITY = 3'd5;

  // configuration register indexes
  localparam int unsigned CFG_ADDR_W = 1;
  localparam logic [CFG_ADDR_W-1:0] CFG_EXPECTED_ABI = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_RELEASE_MODE = 1'd1;

  // crc and counting constants
  localparam logic [31:0] CRC_POLY  = 32'hedb88320;
  localparam logic [31:0] CRC_INIT  = 32'hffffffff;
  localparam int unsigned CNT_W     = 21;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0] HDR_LEN = 21'd12;
  localparam logic [CNT_W-1:0] HDR_MIN_PAYLOAD = 21'd16;

  // codec and flag bytes of the compressed formats
  localparam logic [7:0] CODEC_C565   = 8'h18;
  localparam logic [7:0] FLAGS_C565   = 8'h10;
  localparam logic [7:0] CODEC_C565A8 = 8'h1c;
  localparam logic [7:0] FLAGS_C565A8 = 8'h18;

  // pixel formats
  localparam logic [2:0] FMT_RAW565    = 3'd1;
  localparam logic [2:0] FMT_RAW565A8  = 3'd2;
  localparam logic [2:0] FMT_C565      = 3'd3;
  localparam logic [2:0] FMT_C565A8    = 3'd4;

  // input tdata layout, first field in the lowest bits
  typedef struct packed {
    logic [3:0]  pad;
    logic [7:0]  payload_byte;
    logic [31:0] expected_crc;
    logic        release_ok;
    logic [15:0] codec_and_flags;
    logic [31:0] payload_len;
    logic [31:0] alpha_stride;
    logic [31:0] rgb_stride;
    logic [2:0]  pix_format;
    logic [15:0] img_height;
    logic [15:0] img_width;
    logic [15:0] meta_version;
  } item_t;

  // output tdata layout
  typedef struct packed {
    logic [4:0]  pad;
    logic [31:0] computed_crc;
    logic [2:0]  status;
  } result_t;

  // stored descriptor with checks that only depend on the descriptor
  typedef struct packed {
    logic [15:0] meta_version;
    logic [15:0] img_width;
    logic [15:0] img_height;
    logic [2:0]  pix_format;
    logic [31:0] payload_len;
    logic [7:0]  codec;
    logic [7:0]  flags;
    logic        release_ok;
    logic [31:0] expected_crc;
    logic        geom_ok;
    logic        len_ok;
    logic        codec_match;
    logic [33:0] raw_size;
  } desc_t;

  typedef logic [11:0][7:0] hdr_t;

  // one payload byte through the reflected crc, lsb first
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

// File: src/irv_judge.sv
// ----------------------------------------------------------------------------
// irv_judge
// End-of-payload status decision: the first failing check sets the status.
// ----------------------------------------------------------------------------
module irv_judge import irv_pkg::*; (
  input  desc_t              desc,
  input  hdr_t               hdr,
  input  logic [CNT_W-1:0]   byte_count,
  input  logic [31:0]        crc_reg,
  input  logic [15:0]        expected_abi,
  input  logic               release_mode,
  output logic [2:0]         status
);

  logic [31:0] n32;
  logic [31:0] hdr_len;
  logic [15:0] hdr_w;
  logic [15:0] hdr_h;
  logic        is_raw;
  logic        hdr_bad;

  assign n32     = {{(32-CNT_W){1'b0}}, byte_count};
  assign hdr_len = {hdr[0], hdr[1], hdr[2], hdr[3]};
  assign hdr_w   = {hdr[8], hdr[9]};
  assign hdr_h   = {hdr[10], hdr[11]};
  assign is_raw  = (desc.pix_format == FMT_RAW565) || (desc.pix_format == FMT_RAW565A8);

  // compressed header fields against the descriptor
  assign hdr_bad = !desc.codec_match || (hdr[4] != desc.codec) || (hdr[5] != desc.flags) ||
                   (hdr_w != desc.img_width) || (hdr_h != desc.img_height);

  // check order matters
  always_comb begin
    priority if (desc.meta_version != expected_abi) begin
      status = ST_VERSION;
    end else if (!desc.geom_ok) begin
      status = ST_GEOMETRY;
    end else if (!desc.len_ok || (n32 != desc.payload_len)) begin
      status = ST_SIZE;
    end else if (is_raw && ({13'd0, byte_count} != desc.raw_size)) begin
      status = ST_SIZE;
    end else if (!is_raw && ((byte_count < HDR_MIN_PAYLOAD) || (hdr_len != n32))) begin
      status = ST_SIZE;
    end else if (!is_raw && hdr_bad) begin
      status = ST_GEOMETRY;
    end else if (release_mode && !desc.release_ok) begin
      status = ST_NO_PUBLISH;
    end else if (~crc_reg != desc.expected_crc) begin
      status = ST_INTEGRITY;
    end else begin
      status = ST_OK;
    end
  end

endmodule

// File: src/image_resource_validator_top.sv
// ----------------------------------------------------------------------------
// image_resource_validator_top
// Checks one image resource streamed as descriptor, payload bytes and end.
// ----------------------------------------------------------------------------
// Usage: in_tuser selects the transaction kind (descriptor, payload byte,
// end). A descriptor stores the image metadata and starts a new payload; each
// payload byte updates a reflected CRC-32, a saturating byte count and the
// first twelve header bytes; an end transaction yields one result on the out_
// channel with the status and the final CRC, then restarts the CRC and count.
// Configuration (expected ABI, release mode) is written through cfg_ while no
// transaction is in flight.
// Path: an end transaction waits in the input register until the result
// slot is free, then loads the result register. Throughput: one transaction
// per cycle while no end transaction waits for the result slot; the byte-wide
// CRC update is combinational between the input register and the state registers.
// Reset: rst_n low clears the CRC to all ones, the count, the configuration
// and both valid flags; the descriptor and header bytes hold no value until
// written.
// Stall: while out_tready is low the result waits in the result register;
// payload and descriptor transactions still flow, and a second end
// transaction holds in the input register, which then drops in_tready.
// ----------------------------------------------------------------------------
module image_resource_validator_top import irv_pkg::*; #(
  parameter int unsigned MAX_IMG_WIDTH     = 390,
  parameter int unsigned MAX_IMG_HEIGHT    = 450,
  parameter int unsigned MAX_PAYLOAD_BYTES = 1048576
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // meta_version, img_width, img_height, pix_format, rgb_stride,
  // alpha_stride, payload_len, codec_and_flags, release_ok, expected_crc,
  // payload_byte, zero fill
  input  logic [207:0]          in_tdata,
  // opcode
  input  logic [1:0]            in_tuser,
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // status, computed_crc, zero fill
  output logic [39:0]           out_tdata,
  // configuration writes
  input  logic                  cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [15:0]           cfg_wdata
);

  // input register
  logic             s_valid_r;
  logic [1:0]       s_op_r;
  item_t            s_item_r;
  logic             s_adv;

  // processing state
  logic [31:0]      crc_r, crc_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  hdr_t             hdr_r;
  desc_t            desc_r, desc_nxt;
  logic [15:0]      exp_abi_r;
  logic             rel_mode_r;

  // result register
  logic             o_valid_r;
  result_t          o_data_r;
  logic [2:0]       status;

  // descriptor precompute
  logic [31:0]      wh_prod;
  logic [31:0]      w32, h32, w2;
  logic             fmt_ok;

  // end items wait for a free result slot, everything else passes
  assign s_adv     = s_valid_r && ((s_op_r != OP_END) || !o_valid_r || out_tready);
  assign in_tready = !s_valid_r || s_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (in_tready) begin
      s_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s_op_r   <= in_tuser;
      s_item_r <= item_t'(in_tdata);
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_abi_r  <= 16'd0;
      rel_mode_r <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        CFG_EXPECTED_ABI: exp_abi_r  <= cfg_wdata;
        CFG_RELEASE_MODE: rel_mode_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // descriptor checks that need no payload
  assign w32     = {16'd0, s_item_r.img_width};
  assign h32     = {16'd0, s_item_r.img_height};
  assign w2      = {15'd0, s_item_r.img_width, 1'b0};
  assign wh_prod = w32 * h32;
  assign fmt_ok  = (s_item_r.pix_format >= FMT_RAW565) && (s_item_r.pix_format <= FMT_C565A8);

  always_comb begin
    desc_nxt.meta_version = s_item_r.meta_version;
    desc_nxt.img_width    = s_item_r.img_width;
    desc_nxt.img_height   = s_item_r.img_height;
    desc_nxt.pix_format   = s_item_r.pix_format;
    desc_nxt.payload_len  = s_item_r.payload_len;
    desc_nxt.codec        = s_item_r.codec_and_flags[15:8];
    desc_nxt.flags        = s_item_r.codec_and_flags[7:0];
    desc_nxt.release_ok   = s_item_r.release_ok;
    desc_nxt.expected_crc = s_item_r.expected_crc;
    desc_nxt.geom_ok      = (w32 != 32'd0) && (w32 <= 32'(MAX_IMG_WIDTH)) &&
                            (h32 != 32'd0) && (h32 <= 32'(MAX_IMG_HEIGHT)) && fmt_ok &&
                            (s_item_r.rgb_stride == w2) &&
                            (s_item_r.alpha_stride == (s_item_r.pix_format[0] ? 32'd0 : w32));
    desc_nxt.len_ok       = (s_item_r.payload_len != 32'd0) &&
                            (s_item_r.payload_len <= 32'(MAX_PAYLOAD_BYTES));
    desc_nxt.codec_match  = (s_item_r.pix_format == FMT_C565) ?
                            (s_item_r.codec_and_flags == {CODEC_C565, FLAGS_C565}) :
                            (s_item_r.codec_and_flags == {CODEC_C565A8, FLAGS_C565A8});
    desc_nxt.raw_size     = (s_item_r.pix_format == FMT_RAW565) ?
                            {1'b0, wh_prod, 1'b0} :
                            ({1'b0, wh_prod, 1'b0} + {2'b00, wh_prod});
  end

  // status decision for end items
  irv_judge u_judge (
    .desc         (desc_r),
    .hdr          (hdr_r),
    .byte_count   (count_r),
    .crc_reg      (crc_r),
    .expected_abi (exp_abi_r),
    .release_mode (rel_mode_r),
    .status       (status)
  );

  // crc and count next values
  always_comb begin
    crc_nxt   = crc_r;
    count_nxt = count_r;
    if (s_adv) begin
      unique case (s_op_r)
        OP_DESC, OP_END: begin
          crc_nxt   = CRC_INIT;
          count_nxt = '0;
        end
        OP_BYTE: begin
          crc_nxt   = crc_byte(crc_r, s_item_r.payload_byte);
          count_nxt = (count_r != CNT_MAX) ? count_r + CNT_W'(1) : count_r;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r   <= CRC_INIT;
      count_r <= '0;
    end else begin
      crc_r   <= crc_nxt;
      count_r <= count_nxt;
    end
  end

  // descriptor and header byte storage
  always_ff @(posedge clk) begin
    if (s_adv && (s_op_r == OP_DESC)) begin
      desc_r <= desc_nxt;
    end
    if (s_adv && (s_op_r == OP_BYTE) && (count_r < HDR_LEN)) begin
      hdr_r[count_r[3:0]] <= s_item_r.payload_byte;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (s_adv && (s_op_r == OP_END)) begin
      o_valid_r <= 1'b1;
    end else if (out_tready) begin
      o_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_adv && (s_op_r == OP_END)) begin
      o_data_r.pad          <= '0;
      o_data_r.computed_crc <= ~crc_r;
      o_data_r.status       <= status;
    end
  end

  assign out_tvalid = o_valid_r;
  assign out_tdata  = 40'(o_data_r);

  // an end transaction restarts the payload
  a_end_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (s_adv && (s_op_r == OP_END)) |=> ((crc_r == CRC_INIT) && (count_r == '0)))
    else $error("crc or count not restarted after end");

  // the input side only stalls behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s_valid_r && (s_op_r == OP_END) && o_valid_r && !out_tready))
    else $error("input stalled without a blocked result");

  // a result appears only after an end transaction
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(o_valid_r) |-> $past(s_adv && (s_op_r == OP_END)))
    else $error("result without end transaction");

  // a payload byte always leaves a nonzero count
  a_count_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (s_adv && (s_op_r == OP_BYTE)) |=> (count_r != '0))
    else $error("count did not advance on payload byte");

endmodule
